// File: sv/infix_expression_validator_defines.svh
// assertion macros for the infix expression validator
`ifndef INFIX_EXPRESSION_VALIDATOR_DEFINES_SVH
`define INFIX_EXPRESSION_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define IEV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iev assertion failed");

// next-cycle implication, checked on every clock edge outside reset
`define IEV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iev assertion failed");

`endif

// File: sv/iev_pkg.sv
// types and constants shared by the infix expression validator modules
package iev_pkg;

  localparam int unsigned MaskW = 12;

  localparam logic [MaskW-1:0] K_NUM   = 12'h001;
  localparam logic [MaskW-1:0] K_OP    = 12'h002;
  localparam logic [MaskW-1:0] K_UN    = 12'h004;
  localparam logic [MaskW-1:0] K_EOP   = 12'h008;
  localparam logic [MaskW-1:0] K_FN    = 12'h010;
  localparam logic [MaskW-1:0] K_OPEN  = 12'h020;
  localparam logic [MaskW-1:0] K_CLOSE = 12'h040;
  localparam logic [MaskW-1:0] K_X     = 12'h080;
  localparam logic [MaskW-1:0] K_CE    = 12'h100;
  localparam logic [MaskW-1:0] K_DOT   = 12'h200;
  localparam logic [MaskW-1:0] K_EXP   = 12'h400;
  localparam logic [MaskW-1:0] K_FACT  = 12'h800;

  localparam logic [MaskW-1:0] MASK_START = K_NUM | K_UN | K_FN | K_OPEN | K_X | K_CE;
  localparam logic [MaskW-1:0] MASK_OPERAND = K_NUM | K_FN | K_OPEN | K_X | K_CE | K_UN;

  localparam int unsigned MidDepth = 2;
  localparam int unsigned ResDepth = 2;

  typedef enum logic [3:0] {
    CLS_DIGIT,
    CLS_OP,
    CLS_NAME,
    CLS_X,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_DOT,
    CLS_FACT,
    CLS_EXP,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    cls_e       cls;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [MaskW-1:0] mask;
    logic             depth_zero;
    logic             name_idle;
  } stat_t;

endpackage

// File: sv/iev_fifo.sv
// small first-in first-out queue of words
module iev_fifo #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW:0]  wr_q, wr_d;
  logic [AW:0]  rd_q, rd_d;

  assign empty_o = (wr_q == rd_q);
  assign full_o  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
  assign rdata_o = mem_q[rd_q[AW-1:0]];

  assign wr_d = wr_q + (AW+1)'(push_i && !full_o);
  assign rd_d = rd_q + (AW+1)'(pop_i && !empty_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

// File: sv/iev_front.sv
// front end: sorts each incoming character into its token class
module iev_front (
  input  logic          [7:0] character_i,
  input  logic                last_i,
  output iev_pkg::word_t      word_o
);

  iev_pkg::cls_e cls;

  always_comb begin
    if (character_i >= "0" && character_i <= "9") begin
      cls = iev_pkg::CLS_DIGIT;
    end else if (character_i == "+" || character_i == "-" || character_i == "/" ||
                 character_i == "*" || character_i == "^" || character_i == "%") begin
      cls = iev_pkg::CLS_OP;
    end else if (character_i == "s" || character_i == "c" || character_i == "t" ||
                 character_i == "a" || character_i == "l") begin
      cls = iev_pkg::CLS_NAME;
    end else if (character_i == "x") begin
      cls = iev_pkg::CLS_X;
    end else if (character_i == "(") begin
      cls = iev_pkg::CLS_OPEN;
    end else if (character_i == ")") begin
      cls = iev_pkg::CLS_CLOSE;
    end else if (character_i == ".") begin
      cls = iev_pkg::CLS_DOT;
    end else if (character_i == "!") begin
      cls = iev_pkg::CLS_FACT;
    end else if (character_i == "e" || character_i == "E") begin
      cls = iev_pkg::CLS_EXP;
    end else begin
      cls = iev_pkg::CLS_OTHER;
    end
  end

  assign word_o.ch   = character_i;
  assign word_o.cls  = cls;
  assign word_o.last = last_i;

endmodule

// File: sv/iev_back.sv
// back end: grammar state update and verdict on the last character
module iev_back #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  iev_pkg::word_t      word_i,
  output logic                res_push_o,
  output logic                res_o,
  output iev_pkg::stat_t      stat_o
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_DEPTH);

  localparam logic [3:0] N_IDLE = 4'd0;
  localparam logic [3:0] N_S    = 4'd1;
  localparam logic [3:0] N_IN   = 4'd2;
  localparam logic [3:0] N_N    = 4'd3;
  localparam logic [3:0] N_RT   = 4'd4;
  localparam logic [3:0] N_T    = 4'd5;
  localparam logic [3:0] N_OS   = 4'd6;
  localparam logic [3:0] N_SS   = 4'd7;
  localparam logic [3:0] N_AN   = 4'd8;
  localparam logic [3:0] N_A    = 4'd9;
  localparam logic [3:0] N_L    = 4'd10;
  localparam logic [3:0] N_G    = 4'd11;
  localparam logic [3:0] N_FAIL = 4'd14;
  localparam logic [3:0] N_DONE = 4'd15;

  function automatic logic [3:0] name_next(input logic [3:0] node, input logic [7:0] c);
    logic [3:0] nx;
    nx = N_FAIL;
    case (node)
      N_IDLE: begin
        if (c == "s") nx = N_S;
        else if (c == "c") nx = N_OS;
        else if (c == "t") nx = N_AN;
        else if (c == "a") nx = N_A;
        else if (c == "l") nx = N_L;
      end
      N_S: begin
        if (c == "i") nx = N_N;
        else if (c == "q") nx = N_RT;
      end
      N_A: begin
        if (c == "s") nx = N_IN;
        else if (c == "c") nx = N_OS;
        else if (c == "t") nx = N_AN;
      end
      N_IN: if (c == "i") nx = N_N;
      N_N:  if (c == "n") nx = N_DONE;
      N_RT: if (c == "r") nx = N_T;
      N_T:  if (c == "t") nx = N_DONE;
      N_OS: if (c == "o") nx = N_SS;
      N_SS: if (c == "s") nx = N_DONE;
      N_AN: if (c == "a") nx = N_N;
      N_L: begin
        if (c == "n") nx = N_DONE;
        else if (c == "o") nx = N_G;
      end
      N_G:  if (c == "g") nx = N_DONE;
      default: nx = N_FAIL;
    endcase
    return nx;
  endfunction

  logic [iev_pkg::MaskW-1:0] mask_q, mask_d;
  logic [DepthW-1:0]         depth_q, depth_d;
  logic                      dot_q, dot_d;
  logic [1:0]                ecnt_q, ecnt_d;
  logic                      fpend_q, fpend_d;
  logic                      eopen_q, eopen_d;
  logic [3:0]                name_q, name_d;
  logic [3:0]                nx;
  logic                      is_pm;
  logic                      ok;
  logic [iev_pkg::MaskW-1:0] unary_mask;

  assign is_pm = (word_i.ch == "+") || (word_i.ch == "-");
  assign unary_mask = ((mask_q & (iev_pkg::K_UN | iev_pkg::K_EOP)) != '0) ?
                      (iev_pkg::K_NUM | iev_pkg::K_FN | iev_pkg::K_OPEN |
                       iev_pkg::K_X | iev_pkg::K_CE) : '0;
  assign nx = name_next(name_q, word_i.ch);

  always_comb begin
    mask_d  = mask_q;
    depth_d = depth_q;
    dot_d   = dot_q;
    ecnt_d  = ecnt_q;
    fpend_d = fpend_q;
    eopen_d = eopen_q;
    name_d  = name_q;
    ok      = 1'b0;
    if (mask_q != '0) begin
      if (name_q != N_IDLE) begin
        if (nx == N_FAIL) begin
          mask_d = '0;
          name_d = N_IDLE;
        end else if (nx == N_DONE) begin
          name_d = N_IDLE;
          if ((mask_q & iev_pkg::K_FN) != '0) begin
            mask_d  = iev_pkg::K_OPEN;
            fpend_d = 1'b1;
          end else begin
            mask_d = '0;
          end
        end else begin
          name_d = nx;
        end
      end else begin
        case (word_i.cls)
          iev_pkg::CLS_DIGIT: begin
            if ((mask_q & iev_pkg::K_NUM) != '0) begin
              mask_d = iev_pkg::K_NUM | iev_pkg::K_OP | iev_pkg::K_DOT |
                       iev_pkg::K_EXP | iev_pkg::K_CLOSE |
                       (dot_q ? '0 : iev_pkg::K_FACT);
              eopen_d = 1'b0;
            end else begin
              mask_d = '0;
            end
          end
          iev_pkg::CLS_OP: begin
            if ((mask_q & iev_pkg::K_OP) != '0) begin
              mask_d  = iev_pkg::MASK_OPERAND;
              eopen_d = 1'b0;
              ecnt_d  = 2'd0;
              dot_d   = 1'b0;
            end else if ((mask_q & iev_pkg::K_EOP) != '0 || is_pm) begin
              mask_d = unary_mask;
            end else begin
              mask_d = '0;
            end
          end
          iev_pkg::CLS_NAME: name_d = nx;
          iev_pkg::CLS_X: begin
            mask_d = ((mask_q & iev_pkg::K_X) != '0) ?
                     (iev_pkg::K_OP | iev_pkg::K_CLOSE) : '0;
          end
          iev_pkg::CLS_OPEN: begin
            if ((mask_q & iev_pkg::K_OPEN) != '0 && depth_q < DepthMax) begin
              mask_d  = iev_pkg::MASK_OPERAND;
              fpend_d = 1'b0;
              depth_d = depth_q + 1'b1;
            end else begin
              mask_d = '0;
            end
          end
          iev_pkg::CLS_CLOSE: begin
            if ((mask_q & iev_pkg::K_CLOSE) != '0 && depth_q != '0) begin
              mask_d  = iev_pkg::K_OP | iev_pkg::K_CLOSE;
              depth_d = depth_q - 1'b1;
            end else begin
              mask_d = '0;
            end
          end
          iev_pkg::CLS_DOT: begin
            if ((mask_q & iev_pkg::K_DOT) != '0 && !dot_q) begin
              mask_d = iev_pkg::K_NUM;
              dot_d  = 1'b1;
            end else begin
              mask_d = '0;
            end
          end
          iev_pkg::CLS_FACT: begin
            mask_d = ((mask_q & iev_pkg::K_FACT) != '0) ? iev_pkg::K_OP : '0;
          end
          iev_pkg::CLS_EXP: begin
            if ((mask_q & iev_pkg::K_EXP) != '0) begin
              mask_d  = iev_pkg::K_EOP | iev_pkg::K_NUM;
              dot_d   = 1'b0;
              ecnt_d  = (ecnt_q != 2'd3) ? ecnt_q + 2'd1 : ecnt_q;
              eopen_d = 1'b1;
            end else if ((mask_q & iev_pkg::K_CE) != '0) begin
              mask_d = iev_pkg::K_OP | iev_pkg::K_CLOSE;
            end else begin
              mask_d = '0;
            end
          end
          default: mask_d = '0;
        endcase
        if (ecnt_d > 2'd1) begin
          mask_d = '0;
        end
      end
    end
    if (word_i.last) begin
      ok = (mask_d != '0) && !fpend_d && !eopen_d && (depth_d == '0) &&
           (name_d == N_IDLE) && (word_i.cls != iev_pkg::CLS_OPEN) &&
           (word_i.cls != iev_pkg::CLS_DOT) && (word_i.cls != iev_pkg::CLS_OP);
      mask_d  = iev_pkg::MASK_START;
      depth_d = '0;
      dot_d   = 1'b0;
      ecnt_d  = 2'd0;
      fpend_d = 1'b0;
      eopen_d = 1'b0;
      name_d  = N_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= iev_pkg::MASK_START;
      depth_q <= '0;
      dot_q   <= 1'b0;
      ecnt_q  <= 2'd0;
      fpend_q <= 1'b0;
      eopen_q <= 1'b0;
      name_q  <= N_IDLE;
    end else if (en_i) begin
      mask_q  <= mask_d;
      depth_q <= depth_d;
      dot_q   <= dot_d;
      ecnt_q  <= ecnt_d;
      fpend_q <= fpend_d;
      eopen_q <= eopen_d;
      name_q  <= name_d;
    end
  end

  assign res_push_o = en_i && word_i.last;
  assign res_o      = ok;

  assign stat_o.mask       = mask_q;
  assign stat_o.depth_zero = (depth_q == '0);
  assign stat_o.name_idle  = (name_q == N_IDLE);

endmodule

// File: sv/infix_expression_validator.sv
// top level of the infix expression validator
// Takes one expression character per cycle, push with full as back-pressure, and
// gives one verdict word (valid_res_o) for each character marked last_i, read with
// pop while empty is low. A character crosses a two-word queue from the
// classifier to the grammar state update, which retires one character per cycle
// while the verdict queue has room, writing the verdict into that queue as it
// retires the last character. A new expression may follow its predecessor's
// last character in the next cycle. Brackets nest up to MAX_DEPTH levels.
`include "infix_expression_validator_defines.svh"

module infix_expression_validator #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] character_i,
  input  logic       last_i,
  input  logic       push,
  output logic       full,
  output logic       valid_res_o,
  output logic       empty,
  input  logic       pop
);

  localparam int unsigned WordW = $bits(iev_pkg::word_t);

  iev_pkg::word_t in_word;
  iev_pkg::word_t mid_word;
  logic [WordW-1:0] mid_rdata;
  logic             mid_empty;
  logic             mid_pop;
  logic             res_full;
  logic             res_push;
  logic             res_bit;
  iev_pkg::stat_t   stat;

  iev_front u_front (
    .character_i (character_i),
    .last_i      (last_i),
    .word_o      (in_word)
  );

  iev_fifo #(
    .W     (WordW),
    .DEPTH (iev_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_word),
    .full_o  (full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_word = iev_pkg::word_t'(mid_rdata);
  assign mid_pop  = !mid_empty && !res_full;

  iev_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (mid_pop),
    .word_i     (mid_word),
    .res_push_o (res_push),
    .res_o      (res_bit),
    .stat_o     (stat)
  );

  iev_fifo #(
    .W     (1),
    .DEPTH (iev_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_bit),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (valid_res_o),
    .empty_o (empty)
  );

  // a full input queue always holds words for the back end
  `IEV_ASSERT_SAME(a_full_not_empty, full, !mid_empty)
  // after a verdict the grammar state is back at its start
  `IEV_ASSERT_NEXT(a_restart, mid_pop && mid_word.last,
                   stat.mask == iev_pkg::MASK_START && stat.depth_zero && stat.name_idle)
  // a rejected expression stays rejected until its last word
  `IEV_ASSERT_NEXT(a_reject_sticks, mid_pop && !mid_word.last && stat.mask == '0,
                   stat.mask == '0)

endmodule

// File: tb/sv/infix_expression_validator_tb.sv
// self-checking testbench for the infix expression validator: grammar predictor and verdict queue
module infix_expression_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH_LIMIT = 15;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    NM_IDLE = 4'd0,
    NM_S    = 4'd1,
    NM_IN   = 4'd2,
    NM_N    = 4'd3,
    NM_RT   = 4'd4,
    NM_T    = 4'd5,
    NM_OS   = 4'd6,
    NM_SS   = 4'd7,
    NM_AN   = 4'd8,
    NM_A    = 4'd9,
    NM_L    = 4'd10,
    NM_G    = 4'd11,
    NM_FAIL = 4'd14,
    NM_DONE = 4'd15
  } name_node_e;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
  } keystroke_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic [7:0] character_i = 8'd0;
  logic       last_i = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic       valid_res_o;

  keystroke_t  keystrokes_waiting[$];
  logic        verdicts_due[$];
  int          mismatches = 0;
  int unsigned queued_chars = 0;
  int unsigned push_idle_pct = 27;
  int unsigned pop_idle_pct = 81;
  logic        long_hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  // grammar predictor state
  logic [iev_pkg::MaskW-1:0] mask_now = iev_pkg::MASK_START;
  int unsigned      nest_depth = 0;
  logic             dot_taken = 1'b0;
  logic [1:0]       exp_count = 2'd0;
  logic             fn_pending = 1'b0;
  logic             exp_open = 1'b0;
  name_node_e       name_pos = NM_IDLE;
  logic             tail_operator = 1'b0;

  string fn_names[9] = '{"sin", "cos", "tan", "asin", "acos", "atan", "sqrt", "ln", "log"};
  string op_chars[6] = '{"+", "-", "/", "*", "^", "%"};
  string directed_cases[22] = '{
    "12.5e-3*x", "-(x^2)%e", "sin(x)/cos(E)", "tan(1)+asin(0)", "acos(1)-atan(2)",
    "sqrt(4)^ln(2)*log(9)", "3!", "2.5!", "1e*5", "1e2e3", "1#2", "sx", "lo", ")",
    "1(", "(1", "7+", "-", "1.", "1..2", "sin", "9e"
  };

  infix_expression_validator #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .character_i(character_i),
    .last_i     (last_i),
    .push       (push),
    .full       (full),
    .valid_res_o(valid_res_o),
    .empty      (empty),
    .pop        (pop)
  );

  initial forever #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic logic is_operator(logic [7:0] c);
    return c == "+" || c == "-" || c == "/" || c == "*" || c == "^" || c == "%";
  endfunction

  function automatic name_node_e name_follow(name_node_e node, logic [7:0] c);
    case (node)
      NM_IDLE: begin
        if (c == "s") return NM_S;
        if (c == "c") return NM_OS;
        if (c == "t") return NM_AN;
        if (c == "a") return NM_A;
        if (c == "l") return NM_L;
      end
      NM_S: begin
        if (c == "i") return NM_N;
        if (c == "q") return NM_RT;
      end
      NM_A: begin
        if (c == "s") return NM_IN;
        if (c == "c") return NM_OS;
        if (c == "t") return NM_AN;
      end
      NM_IN: if (c == "i") return NM_N;
      NM_N: if (c == "n") return NM_DONE;
      NM_RT: if (c == "r") return NM_T;
      NM_T: if (c == "t") return NM_DONE;
      NM_OS: if (c == "o") return NM_SS;
      NM_SS: if (c == "s") return NM_DONE;
      NM_AN: if (c == "a") return NM_N;
      NM_L: begin
        if (c == "n") return NM_DONE;
        if (c == "o") return NM_G;
      end
      NM_G: if (c == "g") return NM_DONE;
      default: ;
    endcase
    return NM_FAIL;
  endfunction

  function automatic void clear_grammar();
    mask_now = iev_pkg::MASK_START;
    nest_depth = 0;
    dot_taken = 1'b0;
    exp_count = 2'd0;
    fn_pending = 1'b0;
    exp_open = 1'b0;
    name_pos = NM_IDLE;
    tail_operator = 1'b0;
  endfunction

  function automatic void advance_grammar(logic [7:0] c);
    logic [iev_pkg::MaskW-1:0] m;
    name_node_e nx;
    m = mask_now;
    if (name_pos != NM_IDLE) begin
      nx = name_follow(name_pos, c);
      if (nx == NM_FAIL) begin
        mask_now = '0;
        name_pos = NM_IDLE;
      end else if (nx == NM_DONE) begin
        name_pos = NM_IDLE;
        if ((m & iev_pkg::K_FN) != 0) begin
          mask_now = iev_pkg::K_OPEN;
          fn_pending = 1'b1;
        end else begin
          mask_now = '0;
        end
      end else begin
        name_pos = nx;
      end
      return;
    end
    if (c >= "0" && c <= "9") begin
      if ((m & iev_pkg::K_NUM) != 0) begin
        mask_now = iev_pkg::K_NUM | iev_pkg::K_OP | iev_pkg::K_DOT | iev_pkg::K_EXP |
                   iev_pkg::K_CLOSE;
        if (!dot_taken) mask_now = mask_now | iev_pkg::K_FACT;
        exp_open = 1'b0;
      end else begin
        mask_now = '0;
      end
    end else if (is_operator(c)) begin
      if ((m & iev_pkg::K_OP) != 0) begin
        mask_now = iev_pkg::MASK_OPERAND;
        exp_open = 1'b0;
        exp_count = 2'd0;
        dot_taken = 1'b0;
      end else if ((m & iev_pkg::K_EOP) != 0 || c == "+" || c == "-") begin
        // unary sign, or the sign of an exponent
        mask_now = ((m & (iev_pkg::K_UN | iev_pkg::K_EOP)) != 0) ?
                   (iev_pkg::K_NUM | iev_pkg::K_FN | iev_pkg::K_OPEN | iev_pkg::K_X |
                    iev_pkg::K_CE) : '0;
      end else begin
        mask_now = '0;
      end
    end else if (c == "s" || c == "c" || c == "t" || c == "a" || c == "l") begin
      name_pos = name_follow(NM_IDLE, c);
    end else if (c == "x") begin
      mask_now = ((m & iev_pkg::K_X) != 0) ? (iev_pkg::K_OP | iev_pkg::K_CLOSE) : '0;
    end else if (c == "(") begin
      if ((m & iev_pkg::K_OPEN) != 0 && nest_depth < DEPTH_LIMIT) begin
        mask_now = iev_pkg::MASK_OPERAND;
        fn_pending = 1'b0;
        nest_depth++;
      end else begin
        mask_now = '0;
      end
    end else if (c == ")") begin
      if ((m & iev_pkg::K_CLOSE) != 0 && nest_depth > 0) begin
        mask_now = iev_pkg::K_OP | iev_pkg::K_CLOSE;
        nest_depth--;
      end else begin
        mask_now = '0;
      end
    end else if (c == ".") begin
      if ((m & iev_pkg::K_DOT) != 0 && !dot_taken) begin
        mask_now = iev_pkg::K_NUM;
        dot_taken = 1'b1;
      end else begin
        mask_now = '0;
      end
    end else if (c == "!") begin
      mask_now = ((m & iev_pkg::K_FACT) != 0) ? iev_pkg::K_OP : '0;
    end else if (c == "e" || c == "E") begin
      if ((m & iev_pkg::K_EXP) != 0) begin
        mask_now = iev_pkg::K_EOP | iev_pkg::K_NUM;
        dot_taken = 1'b0;
        if (exp_count != 2'd3) exp_count++;
        exp_open = 1'b1;
      end else if ((m & iev_pkg::K_CE) != 0) begin
        mask_now = iev_pkg::K_OP | iev_pkg::K_CLOSE;
      end else begin
        mask_now = '0;
      end
    end else begin
      mask_now = '0;
    end
    if (exp_count > 2'd1) mask_now = '0;
  endfunction

  function automatic void grade_char(logic [7:0] c, logic lst);
    logic ok;
    if (mask_now != 0) advance_grammar(c);
    tail_operator = is_operator(c);
    if (lst) begin
      ok = mask_now != 0 && !fn_pending && !exp_open && nest_depth == 0 &&
           name_pos == NM_IDLE && c != "(" && c != "." && !tail_operator;
      verdicts_due.push_back(ok);
      clear_grammar();
    end
  endfunction

  // expression generator
  function automatic string gen_number();
    string s;
    string sg;
    logic frac;
    s = $sformatf("%0d", $urandom_range(0, 999));
    frac = ($urandom_range(0, 3) == 0);
    if (frac) s = $sformatf("%s.%0d", s, $urandom_range(0, 99));
    if ($urandom_range(0, 4) == 0) begin
      sg = ($urandom_range(0, 2) == 0) ? op_chars[$urandom_range(0, 5)] : "";
      s = $sformatf("%s%s%s%0d", s, ($urandom_range(0, 1) != 0) ? "e" : "E", sg,
                    $urandom_range(0, 99));
    end
    if (!frac && $urandom_range(0, 5) == 0) s = {s, "!"};
    return s;
  endfunction

  function automatic string gen_operand(int unsigned lvl);
    string s;
    string sg;
    case ($urandom_range(0, (lvl < 3) ? 9 : 5))
      0, 1, 2: s = gen_number();
      3: s = "x";
      4: s = ($urandom_range(0, 1) != 0) ? "e" : "E";
      5: begin
        sg = ($urandom_range(0, 1) != 0) ? "-" : "+";
        s = {sg, gen_number()};
      end
      6, 7: s = {fn_names[$urandom_range(0, 8)], "(", gen_expr(lvl + 1), ")"};
      default: s = {"(", gen_expr(lvl + 1), ")"};
    endcase
    return s;
  endfunction

  function automatic string gen_expr(int unsigned lvl);
    string s;
    int unsigned n;
    n = $urandom_range(1, (lvl == 0) ? 4 : 2);
    s = gen_operand(lvl);
    for (int unsigned i = 1; i < n; i++) s = {s, op_chars[$urandom_range(0, 5)], gen_operand(lvl)};
    return s;
  endfunction

  task automatic queue_chars(ref logic [7:0] chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      keystrokes_waiting.push_back('{ch: chars[i], lst: (i == chars.size() - 1)});
      queued_chars++;
    end
  endtask

  // mangle: 0 keeps the text, 1 replaces, 2 drops, 3 inserts a char, 4 truncates
  task automatic queue_expr(input string s, input int unsigned mangle);
    logic [7:0] chars[$];
    string junk;
    int unsigned pos;
    int unsigned keep;
    junk = "()+-.eE!x1sq";
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    pos = $urandom_range(0, chars.size() - 1);
    case (mangle)
      1: chars[pos] = 8'($urandom_range(0, 255));
      2: if (chars.size() > 1) chars.delete(pos);
      3: chars.insert(pos, junk[$urandom_range(0, junk.len() - 1)]);
      4: begin
        keep = $urandom_range(1, chars.size());
        while (chars.size() > keep) void'(chars.pop_back());
      end
      default: ;
    endcase
    queue_chars(chars);
  endtask

  task automatic queue_noise();
    logic [7:0] chars[$];
    int unsigned n;
    n = $urandom_range(1, 5);
    repeat (n) chars.push_back(8'($urandom_range(0, 255)));
    queue_chars(chars);
  endtask

  task automatic queue_random(input int unsigned budget);
    int unsigned start;
    int unsigned roll;
    start = queued_chars;
    while (queued_chars - start < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) queue_expr(gen_expr(0), 0);
      else if (roll < 90) queue_expr(gen_expr(0), $urandom_range(1, 4));
      else queue_noise();
    end
  endtask

  task automatic wait_quiet();
    while (keystrokes_waiting.size() != 0 || verdicts_due.size() != 0) @(negedge clk_i);
  endtask

  // sender: an offered word stays on the ports until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (push) begin
        grade_char(character_i, last_i);
        void'(keystrokes_waiting.pop_front());
      end
      if (keystrokes_waiting.size() != 0 && $urandom_range(0, 99) >= push_idle_pct) begin
        push <= 1'b1;
        character_i <= keystrokes_waiting[0].ch;
        last_i <= keystrokes_waiting[0].lst;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk_i) begin : receiver
    logic want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch($sformatf("verdict %0b with no expression pending", valid_res_o));
        end else begin
          want = verdicts_due.pop_front();
          if (valid_res_o !== want)
            flag_mismatch($sformatf("valid_res_o %0b, want %0b", valid_res_o, want));
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (long_hold_req && !hold_taken) begin
        hold_left <= HOLD_CYCLES;
        hold_taken <= 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    string deep;
    logic [7:0] raw[$];
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_cases[i]) queue_expr(directed_cases[i], 0);
    raw.push_back(8'h00);
    raw.push_back(8'hff);
    queue_chars(raw);
    queue_random(150);
    wait_quiet();

    @(negedge clk_i);
    push_idle_pct = 81;
    pop_idle_pct = 27;
    queue_random(150);
    wait_quiet();

    @(negedge clk_i);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (60) queue_expr(($urandom_range(0, 1) != 0) ? "1" : "x", 0);
    // deepest legal nesting, then one level too deep
    deep = "";
    repeat (DEPTH_LIMIT) deep = {deep, "("};
    deep = {deep, "1"};
    repeat (DEPTH_LIMIT) deep = {deep, ")"};
    queue_expr(deep, 0);
    deep = "";
    repeat (DEPTH_LIMIT + 1) deep = {deep, "("};
    queue_expr({deep, "x)"}, 0);
    queue_random(120);
    wait_quiet();

    repeat (8) @(negedge clk_i);
    if (verdicts_due.size() != 0)
      flag_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/iev_pkg.sv
sv/iev_fifo.sv
sv/iev_front.sv
sv/iev_back.sv
sv/infix_expression_validator.sv
tb/sv/infix_expression_validator_tb.sv
